// File: sv/alubs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alubs_pkg
// Shared types and codes for the data-processing ALU with barrel shifter.
// ----------------------------------------------------------------------------
package alubs_pkg;

  localparam int unsigned WordBits = 32;

  typedef logic [WordBits-1:0] alubs_word_t;

  // Data-processing opcodes
  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_ADC = 4'd5,
    OP_SBC = 4'd6,
    OP_RSC = 4'd7,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_CMN = 4'd11,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13,
    OP_BIC = 4'd14,
    OP_MVN = 4'd15
  } alubs_op_t;

  // Barrel shifter kinds
  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } alubs_shift_t;

  // One registered request
  typedef struct packed {
    alubs_op_t    func;
    alubs_word_t  first_value;
    logic         use_immediate;
    logic [7:0]   imm_byte;
    logic [3:0]   rotate_field;
    alubs_word_t  second_reg_value;
    alubs_shift_t shift_kind;
    logic         shift_by_register;
    logic [4:0]   shift_imm;
    logic [7:0]   shift_reg_byte;
    logic         carry_in;
    logic         set_flags;
  } alubs_req_t;

  // Status produced by the ALU alongside the result value
  typedef struct packed {
    logic writes_dest;
    logic flags_update;
    logic v_update;
    logic n;
    logic z;
    logic c;
    logic v;
  } alubs_flags_t;

endpackage

// File: sv/alubs_shifter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alubs_shifter
// Second-operand barrel shifter: rotated immediate or shifted register,
// with the shifter carry-out.
// ----------------------------------------------------------------------------
module alubs_shifter
  import alubs_pkg::*;
(
  input  alubs_req_t  req,
  output alubs_word_t operand,
  output logic        shift_carry
);

  logic [2*WordBits-1:0] imm_pair;
  logic [2*WordBits-1:0] imm_rot;
  alubs_word_t           imm_value;
  logic [4:0]            imm_amt;

  logic [7:0]            amt;
  logic                  rrx;
  alubs_word_t           v;
  logic [WordBits:0]     lsl_t;
  logic [WordBits:0]     lsr_t;
  logic [WordBits:0]     asr_t;
  logic [2*WordBits-1:0] ror_t;
  alubs_word_t           ror_value;
  logic                  is_32;
  logic                  over_32;
  alubs_word_t           reg_value;
  logic                  reg_carry;

  // Rotate the immediate byte right by twice the rotate field
  assign imm_amt   = {req.rotate_field, 1'b0};
  assign imm_pair  = {24'd0, req.imm_byte, 24'd0, req.imm_byte};
  assign imm_rot   = imm_pair >> imm_amt;
  assign imm_value = imm_rot[WordBits-1:0];

  // Pick the shift amount; an immediate zero on LSR/ASR means 32
  always_comb begin
    rrx = 1'b0;
    priority if (req.shift_by_register) begin
      amt = req.shift_reg_byte;
    end else if (req.shift_imm == 5'd0 && req.shift_kind == SH_ROR) begin
      amt = 8'd0;
      rrx = 1'b1;
    end else if (req.shift_imm == 5'd0 && req.shift_kind != SH_LSL) begin
      amt = 8'd32;
    end else begin
      amt = {3'd0, req.shift_imm};
    end
  end

  // Shift the register operand; the extra bit catches the last bit out
  assign v         = req.second_reg_value;
  assign lsl_t     = {1'b0, v} << amt[4:0];
  assign lsr_t     = {v, 1'b0} >> amt[4:0];
  assign asr_t     = $unsigned($signed({v, 1'b0}) >>> amt[4:0]);
  assign ror_t     = {v, v} >> amt[4:0];
  assign ror_value = ror_t[WordBits-1:0];
  assign is_32     = (amt == 8'd32);
  assign over_32   = (amt > 8'd32);

  always_comb begin
    if (rrx) begin
      reg_value = {req.carry_in, v[WordBits-1:1]};
      reg_carry = v[0];
    end else if (amt == 8'd0) begin
      reg_value = v;
      reg_carry = req.carry_in;
    end else begin
      unique case (req.shift_kind)
        SH_LSL: begin
          if (is_32) begin
            reg_value = '0;
            reg_carry = v[0];
          end else if (over_32) begin
            reg_value = '0;
            reg_carry = 1'b0;
          end else begin
            reg_value = lsl_t[WordBits-1:0];
            reg_carry = lsl_t[WordBits];
          end
        end
        SH_LSR: begin
          if (is_32) begin
            reg_value = '0;
            reg_carry = v[WordBits-1];
          end else if (over_32) begin
            reg_value = '0;
            reg_carry = 1'b0;
          end else begin
            reg_value = lsr_t[WordBits:1];
            reg_carry = lsr_t[0];
          end
        end
        SH_ASR: begin
          if (is_32 || over_32) begin
            reg_value = {WordBits{v[WordBits-1]}};
            reg_carry = v[WordBits-1];
          end else begin
            reg_value = asr_t[WordBits:1];
            reg_carry = asr_t[0];
          end
        end
        SH_ROR: begin
          // Carry is the bit rotated into the top, also when amount mod 32 is zero
          reg_value = ror_value;
          reg_carry = ror_value[WordBits-1];
        end
        default: begin
          reg_value = v;
          reg_carry = req.carry_in;
        end
      endcase
    end
  end

  // Select the operand source
  always_comb begin
    if (req.use_immediate) begin
      operand     = imm_value;
      shift_carry = (req.rotate_field == 4'd0) ? req.carry_in : imm_value[WordBits-1];
    end else begin
      operand     = reg_value;
      shift_carry = reg_carry;
    end
  end

endmodule

// File: sv/alubs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alubs_core
// Sixteen-operation ALU with one shared adder and N, Z, C, V flag logic.
// ----------------------------------------------------------------------------
module alubs_core
  import alubs_pkg::*;
(
  input  alubs_req_t   req,
  input  alubs_word_t  operand,
  input  logic         shift_carry,
  output alubs_word_t  result,
  output alubs_flags_t flags
);

  alubs_word_t       a;
  alubs_word_t       add_x;
  alubs_word_t       add_y;
  logic              add_c;
  logic              arith;
  alubs_word_t       logic_res;
  logic [WordBits:0] sum;
  alubs_word_t       ovf_vec;
  logic              compare_op;

  assign a = req.first_value;

  // Route operands to the adder or pick the logical result
  always_comb begin
    add_x     = '0;
    add_y     = '0;
    add_c     = 1'b0;
    arith     = 1'b0;
    logic_res = '0;
    unique case (req.func)
      OP_AND, OP_TST: logic_res = a & operand;
      OP_EOR, OP_TEQ: logic_res = a ^ operand;
      OP_SUB, OP_CMP: begin
        add_x = a;       add_y = ~operand; add_c = 1'b1;         arith = 1'b1;
      end
      OP_RSB: begin
        add_x = operand; add_y = ~a;       add_c = 1'b1;         arith = 1'b1;
      end
      OP_ADD, OP_CMN: begin
        add_x = a;       add_y = operand;  add_c = 1'b0;         arith = 1'b1;
      end
      OP_ADC: begin
        add_x = a;       add_y = operand;  add_c = req.carry_in; arith = 1'b1;
      end
      OP_SBC: begin
        add_x = a;       add_y = ~operand; add_c = req.carry_in; arith = 1'b1;
      end
      OP_RSC: begin
        add_x = operand; add_y = ~a;       add_c = req.carry_in; arith = 1'b1;
      end
      OP_ORR: logic_res = a | operand;
      OP_MOV: logic_res = operand;
      OP_BIC: logic_res = a & ~operand;
      OP_MVN: logic_res = ~operand;
      default: logic_res = '0;
    endcase
  end

  // Shared adder with carry-in
  assign sum     = {1'b0, add_x} + {1'b0, add_y} + {{WordBits{1'b0}}, add_c};
  assign ovf_vec = ~(add_x ^ add_y) & (add_x ^ sum[WordBits-1:0]);

  assign result = arith ? sum[WordBits-1:0] : logic_res;

  // Compare and test opcodes leave the destination alone
  assign compare_op = (req.func == OP_TST) || (req.func == OP_TEQ) ||
                      (req.func == OP_CMP) || (req.func == OP_CMN);

  // Build the flags; logical ops carry the shifter bit and do not update V
  always_comb begin
    flags.writes_dest  = ~compare_op;
    flags.flags_update = req.set_flags;
    flags.v_update     = req.set_flags & arith;
    flags.n            = result[WordBits-1];
    flags.z            = (result == '0);
    flags.c            = arith ? sum[WordBits] : shift_carry;
    flags.v            = arith & ovf_vec[WordBits-1];
  end

endmodule

// File: sv/alu_with_barrel_shifter_flags_unit.sv
`timescale 1ns / 1ps
// Result path: a taken request is held in the request register; its result, with done
//   high, is then registered into the result and flag output registers.
// Throughput: one request per cycle; busy stays low, and the rate is one pass
//   of the barrel shifter and the shared adder between input and result registers.
// Reset: synchronous rst clears the request-valid and done flags; no other state.
// ----------------------------------------------------------------------------
// alu_with_barrel_shifter_flags_unit
// Data-processing ALU with barrel-shifted second operand and condition flags.
// ----------------------------------------------------------------------------
module alu_with_barrel_shifter_flags_unit
  import alubs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  func,
  input  logic [31:0] first_value,
  input  logic        use_immediate,
  input  logic [7:0]  imm_byte,
  input  logic [3:0]  rotate_field,
  input  logic [31:0] second_reg_value,
  input  logic [1:0]  shift_kind,
  input  logic        shift_by_register,
  input  logic [4:0]  shift_imm,
  input  logic [7:0]  shift_reg_byte,
  input  logic        carry_in,
  input  logic        set_flags,
  output logic        done,
  output logic [31:0] result,
  output logic        writes_dest,
  output logic        flags_update,
  output logic        v_update,
  output logic        flag_n,
  output logic        flag_z,
  output logic        flag_c,
  output logic        flag_v
);

  alubs_req_t   req;
  logic         req_valid;
  alubs_word_t  operand;
  logic         shift_carry;
  alubs_word_t  alu_result;
  alubs_flags_t alu_flags;
  logic         accept;

  // Never stall the requester
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Capture the request
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req.func              <= alubs_op_t'(func);
      req.first_value       <= first_value;
      req.use_immediate     <= use_immediate;
      req.imm_byte          <= imm_byte;
      req.rotate_field      <= rotate_field;
      req.second_reg_value  <= second_reg_value;
      req.shift_kind        <= alubs_shift_t'(shift_kind);
      req.shift_by_register <= shift_by_register;
      req.shift_imm         <= shift_imm;
      req.shift_reg_byte    <= shift_reg_byte;
      req.carry_in          <= carry_in;
      req.set_flags         <= set_flags;
    end
  end

  alubs_shifter u_shifter (
    .req         (req),
    .operand     (operand),
    .shift_carry (shift_carry)
  );

  alubs_core u_core (
    .req         (req),
    .operand     (operand),
    .shift_carry (shift_carry),
    .result      (alu_result),
    .flags       (alu_flags)
  );

  // Strobe the result in the cycle after the request register is valid
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      result       <= alu_result;
      writes_dest  <= alu_flags.writes_dest;
      flags_update <= alu_flags.flags_update;
      v_update     <= alu_flags.v_update;
      flag_n       <= alu_flags.n;
      flag_z       <= alu_flags.z;
      flag_c       <= alu_flags.c;
      flag_v       <= alu_flags.v;
    end
  end

  // Every accepted request yields a strobe after the request and result registers
  a_req_to_done: assert property (@(posedge clk) disable iff (rst)
    start |=> ##1 done)
    else $error("accepted request produced no result strobe");

  // No strobe without a request in flight
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !req_valid |=> !done)
    else $error("result strobe without a request");

  // Flags agree with the delivered value
  a_nz_match: assert property (@(posedge clk) disable iff (rst)
    done |-> (flag_n == result[31]) && (flag_z == (result == 32'd0)))
    else $error("N or Z flag disagrees with result");

  // V is only written together with the other flags
  a_v_update: assert property (@(posedge clk) disable iff (rst)
    (done && v_update) |-> flags_update)
    else $error("V update without flag update");

endmodule
